>>> hdl/rfnf_pkg.sv
// ----------------------------------------------------------------------------
// Record field numeric filter package
// Shared constants, register codes, phase and subject encodings, and the
// structures passed between the configuration, parser and compare stages.
// ----------------------------------------------------------------------------
package rfnf_pkg;

    // Field count limit and derived widths.
    localparam int FIELD_CAP  = 512;
    localparam int FIELD_W    = 10;
    localparam int CNT_W      = $clog2(FIELD_CAP + 1);
    localparam int IDX_W      = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int RECNUM_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBJECT_KIND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBJECT_FIELD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_VALUE = 3'd5;

    // Split modes.
    localparam logic SPLIT_BLANKS    = 1'b0;
    localparam logic SPLIT_DELIMITER = 1'b1;

    // Subject kinds.
    localparam logic [1:0] SUBJ_NONE   = 2'd0;
    localparam logic [1:0] SUBJ_FIELD  = 2'd1;
    localparam logic [1:0] SUBJ_RECNUM = 2'd2;
    localparam logic [1:0] SUBJ_FCOUNT = 2'd3;

    // Comparison operators.
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_NE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_GT = 3'd4;
    localparam logic [2:0] OP_GE = 3'd5;

    // Number parser phases.
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic                split_mode;
        logic [BYTE_W-1:0]   delimiter_byte;
        logic [1:0]          subject_kind;
        logic [FIELD_W-1:0]  subject_field;
        logic [2:0]          compare_op;
        logic [VALUE_W-1:0]  compare_value;
    } cfg_t;

    // Finished record handed from the parser to the compare stage.
    typedef struct packed {
        logic [RECNUM_W-1:0] record_number;
        logic [FIELD_W-1:0]  field_count;
        logic [VALUE_W-1:0]  subject_value;
        logic                subject_valid;
    } fin_t;

endpackage

>>> hdl/rfnf_cfg.sv
// ----------------------------------------------------------------------------
// Record field numeric filter configuration registers
// Holds the six control registers, written through a plain write port.
// ----------------------------------------------------------------------------
module rfnf_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rfnf_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rfnf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output rfnf_pkg::cfg_t                    cfg
);
    import rfnf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and take the low bits of the write data.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SPLIT_MODE:    cfg_next.split_mode     = cfg_wr_data[0];
                REG_DELIMITER:     cfg_next.delimiter_byte = cfg_wr_data[BYTE_W-1:0];
                REG_SUBJECT_KIND:  cfg_next.subject_kind   = cfg_wr_data[1:0];
                REG_SUBJECT_FIELD: cfg_next.subject_field  = cfg_wr_data[FIELD_W-1:0];
                REG_COMPARE_OP:    cfg_next.compare_op     = cfg_wr_data[2:0];
                REG_COMPARE_VALUE: cfg_next.compare_value  = cfg_wr_data[VALUE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/rfnf_parse.sv
// ----------------------------------------------------------------------------
// Record field numeric filter parser
// Registers each incoming byte, then updates the record state: field
// splitting, field count and the decimal number parser. A finished record is
// placed in a holding register for the compare stage.
// ----------------------------------------------------------------------------
module rfnf_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rfnf_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rfnf_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_end,
    output logic                          fin_valid,
    input  logic                          fin_take_ready,
    output rfnf_pkg::fin_t                fin
);
    import rfnf_pkg::*;

    // Input register.
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_end_reg;

    // Record state.
    logic [RECNUM_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0]    fields_reg, fields_next;
    logic                inside_reg, inside_next;
    logic                has_bytes_reg, has_bytes_next;
    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                neg_reg, neg_next;

    // Finished record holding register.
    logic fin_valid_reg, fin_valid_next;
    fin_t fin_reg, fin_next;

    logic                fin_ready;
    logic                fire;
    logic                do_finish;
    logic [CNT_W-1:0]    fields_eff;
    logic                inside_eff;
    logic                feed;
    logic                is_digit;
    logic                is_blank;
    logic [VALUE_W-1:0]  digit_val;
    logic [VALUE_W-1:0]  mag_times_ten;
    logic                exists;

    // Handshake between the input register and the holding register.
    assign fin_ready = !fin_valid_reg || fin_take_ready;
    assign in_ready  = !in_valid_reg || fin_ready;
    assign fire      = in_valid_reg && fin_ready;

    assign is_digit      = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign is_blank      = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB);
    assign digit_val     = VALUE_W'(in_byte_reg[3:0]);
    assign mag_times_ten = {mag_reg[VALUE_W-4:0], 3'b000} + {mag_reg[VALUE_W-2:0], 1'b0};

    // The first byte of a record opens field one in delimiter mode.
    assign fields_eff = (!has_bytes_reg && cfg.split_mode == SPLIT_DELIMITER)
                        ? CNT_W'(1) : fields_reg;
    assign inside_eff = (!has_bytes_reg && cfg.split_mode == SPLIT_DELIMITER)
                        ? 1'b1 : inside_reg;

    // Record state update for one byte or end-of-stream marker.
    always_comb begin
        count_next     = count_reg;
        fields_next    = fields_reg;
        inside_next    = inside_reg;
        has_bytes_next = has_bytes_reg;
        phase_next     = phase_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        do_finish      = 1'b0;
        feed           = 1'b0;

        if (fire) begin
            if (in_end_reg) begin
                do_finish = has_bytes_reg;
            end else if (in_byte_reg == CH_NEWLINE) begin
                do_finish = 1'b1;
            end else begin
                has_bytes_next = 1'b1;
                fields_next    = fields_eff;
                inside_next    = inside_eff;
                if (cfg.split_mode == SPLIT_BLANKS) begin
                    if (is_blank) begin
                        inside_next = 1'b0;
                    end else begin
                        if (!inside_eff && fields_eff < CNT_W'(FIELD_CAP)) begin
                            fields_next = fields_eff + CNT_W'(1);
                            inside_next = 1'b1;
                        end
                        feed = inside_next &&
                               (IDX_W'(cfg.subject_field) == IDX_W'(fields_next));
                    end
                end else begin
                    if (in_byte_reg == cfg.delimiter_byte) begin
                        if (fields_eff < CNT_W'(FIELD_CAP)) begin
                            fields_next = fields_eff + CNT_W'(1);
                            inside_next = 1'b1;
                        end else begin
                            inside_next = 1'b0;
                        end
                    end else begin
                        feed = inside_eff &&
                               (IDX_W'(cfg.subject_field) == IDX_W'(fields_eff));
                    end
                end
                if (cfg.subject_field == '0) begin
                    feed = 1'b1;
                end

                // Decimal number parser.
                if (cfg.subject_kind == SUBJ_FIELD && feed) begin
                    unique case (phase_reg)
                        PH_SKIP: begin
                            if (!is_blank) begin
                                if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS) begin
                                    neg_next   = (in_byte_reg == CH_MINUS);
                                    phase_next = PH_SIGN;
                                end else if (is_digit) begin
                                    mag_next   = digit_val;
                                    phase_next = PH_DIGITS;
                                end else begin
                                    phase_next = PH_FAIL;
                                end
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit) begin
                                mag_next   = digit_val;
                                phase_next = PH_DIGITS;
                            end else begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit) begin
                                mag_next = mag_times_ten + digit_val;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end

            // A finished record clears the per-record state.
            if (do_finish) begin
                if (count_reg != '1) begin
                    count_next = count_reg + RECNUM_W'(1);
                end
                fields_next    = '0;
                inside_next    = 1'b0;
                has_bytes_next = 1'b0;
                phase_next     = PH_SKIP;
                mag_next       = '0;
                neg_next       = 1'b0;
            end
        end
    end

    // Subject selection for a finished record.
    assign exists = (cfg.subject_field == '0) ||
                    (IDX_W'(cfg.subject_field) <= IDX_W'(fields_eff));

    always_comb begin
        fin_next               = fin_reg;
        fin_next.record_number = count_next;
        fin_next.field_count   = FIELD_W'(fields_eff);
        fin_next.subject_value = '0;
        fin_next.subject_valid = 1'b0;
        unique case (cfg.subject_kind)
            SUBJ_FIELD: begin
                if (exists && (phase_reg == PH_DIGITS || phase_reg == PH_DONE)) begin
                    fin_next.subject_valid = 1'b1;
                    fin_next.subject_value = neg_reg ? (VALUE_W'(0) - mag_reg) : mag_reg;
                end
            end
            SUBJ_RECNUM: begin
                fin_next.subject_valid = 1'b1;
                fin_next.subject_value = VALUE_W'(count_next);
            end
            SUBJ_FCOUNT: begin
                fin_next.subject_valid = 1'b1;
                fin_next.subject_value = VALUE_W'(fields_eff);
            end
            default: begin
                fin_next.subject_valid = 1'b0;
            end
        endcase
    end

    // Valid flags of the two registers.
    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign fin_valid_next = fire ? do_finish : (fin_take_ready ? 1'b0 : fin_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            count_reg     <= '0;
            fields_reg    <= '0;
            inside_reg    <= 1'b0;
            has_bytes_reg <= 1'b0;
            phase_reg     <= PH_SKIP;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            fin_valid_reg <= fin_valid_next;
            count_reg     <= count_next;
            fields_reg    <= fields_next;
            inside_reg    <= inside_next;
            has_bytes_reg <= has_bytes_next;
            phase_reg     <= phase_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            in_byte_reg <= in_byte;
            in_end_reg  <= in_end;
        end
        if (fire && do_finish) begin
            fin_reg <= fin_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

>>> hdl/rfnf_cmp.sv
// ----------------------------------------------------------------------------
// Record field numeric filter compare stage
// Tests the subject of a finished record against the constant and holds the
// result transaction in the output register.
// ----------------------------------------------------------------------------
module rfnf_cmp (
    input  logic           aclk,
    input  logic           aresetn,
    input  rfnf_pkg::cfg_t cfg,
    input  logic           fin_valid,
    output logic           fin_take_ready,
    input  rfnf_pkg::fin_t fin,
    output logic           out_valid,
    input  logic           out_ready,
    output rfnf_pkg::fin_t out_rec,
    output logic           out_selected
);
    import rfnf_pkg::*;

    logic out_valid_reg, out_valid_next;
    fin_t out_rec_reg;
    logic sel_reg, sel_next;
    logic take;
    logic lt, gt, eq;

    assign fin_take_ready = !out_valid_reg || out_ready;
    assign take           = fin_valid && fin_take_ready;

    // Signed comparison of the subject with the constant.
    assign eq = (fin.subject_value == cfg.compare_value);
    assign lt = ($signed(fin.subject_value) < $signed(cfg.compare_value));
    assign gt = !lt && !eq;

    always_comb begin
        sel_next = 1'b0;
        if (cfg.subject_kind == SUBJ_NONE) begin
            sel_next = 1'b1;
        end else if (fin.subject_valid) begin
            unique case (cfg.compare_op)
                OP_EQ:   sel_next = eq;
                OP_NE:   sel_next = !eq;
                OP_LT:   sel_next = lt;
                OP_LE:   sel_next = lt || eq;
                OP_GT:   sel_next = gt;
                OP_GE:   sel_next = !lt;
                default: sel_next = 1'b0;
            endcase
        end
    end

    assign out_valid_next = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_rec_reg <= fin;
            sel_reg     <= sel_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_rec      = out_rec_reg;
    assign out_selected = sel_reg;

endmodule

>>> hdl/record_field_numeric_filter.sv
// ----------------------------------------------------------------------------
// Record field numeric filter
// Splits a byte stream into newline-terminated records, counts fields and
// tests one numeric subject per record against a signed constant.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock, unless the input is stalled, and
// gives one result transaction per record, when a newline arrives or when an
// end-of-stream marker closes a record that has pending bytes. It accepts a
// new byte every cycle unless stalled as described below. A closing byte
// passes through the input register, then the holding register with the
// record state update, then the compare and output register, before its
// result is offered on the port. Bytes keep flowing while one result waits
// in the output register; once a second finished record sits in the holding
// register behind it, the input stops until the result port takes a
// transaction. Write the configuration only while no record is pending and
// the block is empty.
// ----------------------------------------------------------------------------
module record_field_numeric_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [rfnf_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rfnf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
    input  logic                              s_axis_tuser,  // [0] stream_end
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] record_number, [41:32] field_count, [105:42] subject_value, rest 0
    output logic [111:0]                      m_axis_tdata,
    // [0] line_selected, [1] subject_valid
    output logic [1:0]                        m_axis_tuser
);
    import rfnf_pkg::*;

    cfg_t cfg;
    logic fin_valid;
    logic fin_take_ready;
    fin_t fin;
    fin_t out_rec;
    logic out_selected;

    // Control registers.
    rfnf_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Record splitting and number parsing.
    rfnf_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_byte        (s_axis_tdata),
        .in_end         (s_axis_tuser),
        .fin_valid      (fin_valid),
        .fin_take_ready (fin_take_ready),
        .fin            (fin)
    );

    // Comparison and output register.
    rfnf_cmp u_cmp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .fin_valid      (fin_valid),
        .fin_take_ready (fin_take_ready),
        .fin            (fin),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_rec        (out_rec),
        .out_selected   (out_selected)
    );

    // Pack the result fields.
    assign m_axis_tdata = {6'b000000, out_rec.subject_value, out_rec.field_count,
                           out_rec.record_number};
    assign m_axis_tuser = {out_rec.subject_valid, out_selected};

endmodule
